// ===== rtl/core/erlb_pkg.sv =====
// Package for the Erlang B blocking block: field widths, fixed-point
// constants and width helpers. No dependencies.
package erlb_pkg;

  localparam int unsigned MAX_LINES_DEF = 256;  // default line count limit
  localparam int unsigned LOAD_W        = 16;   // offered load, Q8.8
  localparam int unsigned PROB_W        = 16;   // blocking probability, Q0.16
  localparam int unsigned BPROB_W       = PROB_W + 1;  // holds exactly 1.0
  localparam int unsigned PROD_W        = LOAD_W + PROB_W;  // E*B, Q8.24
  localparam int unsigned LINE_SHIFT    = 24;   // n aligned to Q8.24

  // Bits needed to hold a line count from 0 to max_lines.
  function automatic int unsigned line_width(int unsigned max_lines);
    return $clog2(max_lines + 1);
  endfunction

  // Bits needed for the divisor (n << 24) + E*B with one bit of headroom.
  function automatic int unsigned den_width(int unsigned max_lines);
    int unsigned lw;
    lw = line_width(max_lines) + LINE_SHIFT;
    return ((lw > PROD_W) ? lw : PROD_W) + 1;
  endfunction

endpackage

// ===== rtl/core/erlb_serial_div.sv =====
// Bit-serial restoring divider that produces one quotient bit per cycle.
// Depends on erlb_pkg for widths.
module erlb_serial_div #(
  parameter int unsigned MAX_LINES = erlb_pkg::MAX_LINES_DEF,
  localparam int unsigned DEN_W = erlb_pkg::den_width(MAX_LINES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [erlb_pkg::PROD_W-1:0] num_i,
  input  logic [DEN_W-1:0]            den_i,
  output logic                        done_o,
  output logic [erlb_pkg::PROB_W-1:0] quot_o
);
  import erlb_pkg::*;

  localparam int unsigned CNT_W = $clog2(PROB_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [PROB_W-1:0] quot_q, quot_d;
  logic [DEN_W:0]   shifted;
  logic             fits;

  // The dividend is num << 16 and num < den, so the remainder starts at num
  // and each step only shifts in a zero.
  assign shifted = {rem_q, 1'b0};
  assign fits    = (shifted >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = DEN_W'(num_i);
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d  = fits ? DEN_W'(shifted - {1'b0, den_q}) : DEN_W'(shifted);
      quot_d = {quot_q[PROB_W-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(PROB_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/core/erlang_b_blocking.sv =====
// Top level of the Erlang B blocking probability block.
// Depends on erlb_pkg and erlb_serial_div.
//
// Each request carries an offered load E in erlangs (unsigned Q8.8) and a
// line count N; the block answers with the Erlang B blocking probability as
// a truncated Q0.16 fraction, one result per request. It runs the recurrence
// B(0) = 1, B(n) = E*B(n-1) / (n + E*B(n-1)) for n = 1..N, flooring each
// quotient to 16 fraction bits. A line count above MAX_LINES is treated as
// MAX_LINES, zero load gives 0, and zero lines gives the saturated value
// 0xFFFF. One request is worked on at a time: each recurrence step runs a
// bit-serial shift-add multiplier for E*B, then a state that forms the
// divisor and starts a bit-serial restoring divider (one quotient bit per
// cycle). The finished result sits in an output register, so a new request
// is accepted while the previous result still waits to be taken.
module erlang_b_blocking #(
  parameter int unsigned MAX_LINES = erlb_pkg::MAX_LINES_DEF,
  localparam int unsigned LINE_W = erlb_pkg::line_width(MAX_LINES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [erlb_pkg::LOAD_W-1:0] offered_load_i,
  input  logic [LINE_W-1:0]           line_count_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [erlb_pkg::PROB_W-1:0] blocking_o
);
  import erlb_pkg::*;

  localparam int unsigned DEN_W = den_width(MAX_LINES);
  localparam int unsigned MCNT_W = $clog2(BPROB_W);

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_MUL      = 5'b00010,
    ST_DIV_GO   = 5'b00100,
    ST_DIV_WAIT = 5'b01000,
    ST_HOLD     = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [LOAD_W-1:0]  load_q, load_d;
  logic [LINE_W-1:0]  lines_q, lines_d;
  logic [LINE_W-1:0]  n_q, n_d;
  logic [BPROB_W-1:0] b_q, b_d;        // current B(n), 1.0 = 1 << 16
  logic [BPROB_W-1:0] bsh_q, bsh_d;    // B shifted out MSB first
  logic [PROD_W-1:0]  acc_q, acc_d;    // E*B accumulator
  logic [MCNT_W-1:0]  mcnt_q, mcnt_d;
  logic               out_valid_q, out_valid_d;
  logic [PROB_W-1:0]  out_q, out_d;

  logic               in_accept;
  logic               out_free;
  logic [LINE_W-1:0]  lines_clamped;
  logic               div_start;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;
  logic [PROB_W-1:0]  div_quot;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign lines_clamped = (line_count_i > LINE_W'(MAX_LINES)) ? LINE_W'(MAX_LINES)
                                                             : line_count_i;

  // The divisor is (n << 24) + E*B; the dividend is E*B << 16.
  assign div_start = (state_q == ST_DIV_GO);
  assign div_den = (DEN_W'(n_q) << LINE_SHIFT) + DEN_W'(acc_q);

  erlb_serial_div #(
    .MAX_LINES(MAX_LINES)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (acc_q),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    load_d      = load_q;
    lines_d     = lines_q;
    n_d         = n_q;
    b_d         = b_q;
    bsh_d       = bsh_q;
    acc_d       = acc_q;
    mcnt_d      = mcnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    // The consumer takes the waiting result.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          load_d  = offered_load_i;
          lines_d = lines_clamped;
          n_d     = LINE_W'(1);
          b_d     = BPROB_W'(1) << PROB_W;
          bsh_d   = BPROB_W'(1) << PROB_W;
          acc_d   = '0;
          mcnt_d  = '0;
          // With no lines the answer is B(0) = 1.0, which saturates.
          state_d = (lines_clamped == '0) ? ST_HOLD : ST_MUL;
        end
      end
      ST_MUL: begin
        // Shift-add over the bits of B, most significant first.
        acc_d  = {acc_q[PROD_W-2:0], 1'b0} +
                 (bsh_q[BPROB_W-1] ? PROD_W'(load_q) : '0);
        bsh_d  = {bsh_q[BPROB_W-2:0], 1'b0};
        mcnt_d = mcnt_q + 1'b1;
        if (mcnt_q == MCNT_W'(BPROB_W - 1)) begin
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          b_d = BPROB_W'(div_quot);
          if (n_q == lines_q) begin
            state_d = ST_HOLD;
          end else begin
            n_d     = n_q + 1'b1;
            bsh_d   = BPROB_W'(div_quot);
            acc_d   = '0;
            mcnt_d  = '0;
            state_d = ST_MUL;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_d       = b_q[BPROB_W-1] ? {PROB_W{1'b1}} : b_q[PROB_W-1:0];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      mcnt_q      <= '0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      mcnt_q      <= mcnt_d;
      n_q         <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    load_q  <= load_d;
    lines_q <= lines_d;
    b_q     <= b_d;
    bsh_q   <= bsh_d;
    acc_q   <= acc_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign blocking_o  = out_q;

endmodule
